FILE: sv/target_status_debounce_classifier_core_assert.svh
// Assertion macros for the target status classifier, included by tsdc_back
`ifndef TARGET_STATUS_DEBOUNCE_CLASSIFIER_CORE_ASSERT_SVH
`define TARGET_STATUS_DEBOUNCE_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TSDC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define TSDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/tsdc_pkg.sv
// Types, codes and constants of the target status classifier
`timescale 1ns / 1ps

package tsdc_pkg;

   // Default number of monitored targets
   localparam int unsigned NUM_TARGETS_DEFAULT = 16;

   // Field widths
   localparam int unsigned TARGET_W = 4;
   localparam int unsigned CONF_W   = 10;
   localparam int unsigned LIGHT_W  = 13;
   localparam int unsigned SSIM_W   = 16;
   localparam int unsigned SHIFT_W  = 16;
   localparam int unsigned FRAMES_W = 16;
   localparam int unsigned JUMP_W   = 15;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_ANALYZE   = 2'd0,
      KIND_RESET     = 2'd1,
      KIND_RESET_ALL = 2'd2,
      KIND_REMOVE    = 2'd3
   } kind_type;

   typedef logic [1:0] status_type;
   typedef logic [3:0] reason_type;
   typedef logic [2:0] run_type;

   // Status codes
   localparam status_type ST_INIT   = 2'd0;
   localparam status_type ST_NORMAL = 2'd1;
   localparam status_type ST_WARN   = 2'd2;
   localparam status_type ST_ERROR  = 2'd3;

   // Reason codes
   localparam reason_type RS_OK        = 4'd0;
   localparam reason_type RS_CONF_LOW  = 4'd1;
   localparam reason_type RS_CONF_WARN = 4'd2;
   localparam reason_type RS_SSIM_ERR  = 4'd3;
   localparam reason_type RS_SSIM_WARN = 4'd4;
   localparam reason_type RS_DARK      = 4'd5;
   localparam reason_type RS_BRIGHT    = 4'd6;
   localparam reason_type RS_JUMP      = 4'd7;
   localparam reason_type RS_INIT      = 4'd8;
   localparam reason_type RS_RESET     = 4'd9;

   // Debounce run limits
   localparam run_type RUN_MAX   = 3'd5;
   localparam run_type RUN_SHORT = 3'd3;

   // Jump check applies above this many tracked frames
   localparam logic [FRAMES_W-1:0] JUMP_MIN_FRAMES = 16'd5;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CONF_ERR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONF_WARN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SSIM_ERR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SSIM_WARN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_ERR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_HI  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP      = 3'd6;

   // Configuration reset values
   localparam logic [CONF_W-1:0]         CONF_ERR_RST  = 10'd550;
   localparam logic [CONF_W-1:0]         CONF_WARN_RST = 10'd700;
   localparam logic signed [SSIM_W-1:0]  SSIM_ERR_RST  = 16'sd10650;
   localparam logic signed [SSIM_W-1:0]  SSIM_WARN_RST = 16'sd12288;
   localparam logic [LIGHT_W-1:0]        LIGHT_ERR_RST = 13'd1024;
   localparam logic [LIGHT_W-1:0]        LIGHT_HI_RST  = 13'd3891;
   localparam logic [JUMP_W-1:0]         JUMP_RST      = 15'd1280;

   // Classified request passed from front to back
   typedef struct packed {
      kind_type             kind;
      logic [TARGET_W-1:0]  target;
      status_type           inst;
      reason_type           rsn;
   } op_type;

   // Per-target debounce record
   typedef struct packed {
      status_type state;
      reason_type reason;
      status_type last;
      run_type    run;
   } entry_type;

   localparam entry_type ENTRY_INIT  = '{state: ST_INIT, reason: RS_INIT,
                                         last: ST_INIT, run: 3'd0};
   localparam entry_type ENTRY_RESET = '{state: ST_INIT, reason: RS_RESET,
                                         last: ST_INIT, run: 3'd0};

endpackage

FILE: sv/target_status_debounce_classifier_core.sv
// Top level of the target status debounce classifier
//
//   channel   handshake             carries
//   req_*     req_valid/req_stall   kind, target and one frame's measurements
//   rsp_*     rsp_valid/rsp_stall   confirmed status, reason, normal flag, instant
//   csr_*     csr_valid/csr_ready   threshold register index and write data
//
// Takes one request per cycle; an analysed frame passes through the queue and the
// update stage into the result register. The single read-modify-write stage on
// the per-target record RAM sets the rate and forwards its write to the next
// request of the same target. Reset is synchronous; per-target flags clear at
// once, so no clearing pass follows. A stall on rsp_ holds the result register;
// requests flow into the two-entry queue until it fills and raises req_stall.
`timescale 1ns / 1ps

module target_status_debounce_classifier_core #(
   parameter int unsigned NUM_TARGETS = tsdc_pkg::NUM_TARGETS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tsdc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [tsdc_pkg::TARGET_W-1:0]       req_target,
   input  logic [tsdc_pkg::CONF_W-1:0]         req_confidence,
   input  logic [tsdc_pkg::LIGHT_W-1:0]        req_brightness,
   input  logic signed [tsdc_pkg::SSIM_W-1:0]  req_similarity,
   input  logic signed [tsdc_pkg::SHIFT_W-1:0] req_shift_x,
   input  logic signed [tsdc_pkg::SHIFT_W-1:0] req_shift_y,
   input  logic [tsdc_pkg::FRAMES_W-1:0]       req_frames_tracked,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_confirmed_status,
   output logic [3:0]                          rsp_reason,
   output logic                                rsp_is_normal,
   output logic [1:0]                          rsp_instant_status
);
   import tsdc_pkg::*;

   logic   push_valid;
   op_type push_op;
   logic   queue_full;
   logic   pop;
   logic   head_valid;
   op_type head_op;

   // Accept and classify requests
   tsdc_front #(
      .NUM_TARGETS (NUM_TARGETS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_target         (req_target),
      .req_confidence     (req_confidence),
      .req_brightness     (req_brightness),
      .req_similarity     (req_similarity),
      .req_shift_x        (req_shift_x),
      .req_shift_y        (req_shift_y),
      .req_frames_tracked (req_frames_tracked),
      .queue_full         (queue_full),
      .push_valid         (push_valid),
      .push_op            (push_op)
   );

   // Decouple front and back
   tsdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   // Debounce per target and deliver results
   tsdc_back #(
      .NUM_TARGETS (NUM_TARGETS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head_op              (head_op),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_confirmed_status (rsp_confirmed_status),
      .rsp_reason           (rsp_reason),
      .rsp_is_normal        (rsp_is_normal),
      .rsp_instant_status   (rsp_instant_status)
   );

endmodule

FILE: sv/tsdc_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module tsdc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, hold when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/tsdc_front.sv
// Front part: configuration registers and per-request frame classification
`timescale 1ns / 1ps

module tsdc_front #(
   parameter int unsigned NUM_TARGETS = tsdc_pkg::NUM_TARGETS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tsdc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [tsdc_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_kind,
   input  logic [tsdc_pkg::TARGET_W-1:0]           req_target,
   input  logic [tsdc_pkg::CONF_W-1:0]             req_confidence,
   input  logic [tsdc_pkg::LIGHT_W-1:0]            req_brightness,
   input  logic signed [tsdc_pkg::SSIM_W-1:0]      req_similarity,
   input  logic signed [tsdc_pkg::SHIFT_W-1:0]     req_shift_x,
   input  logic signed [tsdc_pkg::SHIFT_W-1:0]     req_shift_y,
   input  logic [tsdc_pkg::FRAMES_W-1:0]           req_frames_tracked,
   input  logic                                    queue_full,
   output logic                                    push_valid,
   output tsdc_pkg::op_type                        push_op
);
   import tsdc_pkg::*;

   logic [CONF_W-1:0]        conf_err_ff,  conf_err_in;
   logic [CONF_W-1:0]        conf_warn_ff, conf_warn_in;
   logic signed [SSIM_W-1:0] ssim_err_ff,  ssim_err_in;
   logic signed [SSIM_W-1:0] ssim_warn_ff, ssim_warn_in;
   logic [LIGHT_W-1:0]       light_err_ff, light_err_in;
   logic [LIGHT_W-1:0]       light_hi_ff,  light_hi_in;
   logic [JUMP_W-1:0]        jump_ff,      jump_in;

   logic [SHIFT_W:0] mag_x;
   logic [SHIFT_W:0] mag_y;
   logic [SHIFT_W:0] mag_max;
   status_type       inst;
   reason_type       rsn;
   logic             normal;
   logic             in_range;
   kind_type         kind;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      conf_err_in  = conf_err_ff;
      conf_warn_in = conf_warn_ff;
      ssim_err_in  = ssim_err_ff;
      ssim_warn_in = ssim_warn_ff;
      light_err_in = light_err_ff;
      light_hi_in  = light_hi_ff;
      jump_in      = jump_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CONF_ERR:  conf_err_in  = csr_wdata[CONF_W-1:0];
            CSR_CONF_WARN: conf_warn_in = csr_wdata[CONF_W-1:0];
            CSR_SSIM_ERR:  ssim_err_in  = $signed(csr_wdata[SSIM_W-1:0]);
            CSR_SSIM_WARN: ssim_warn_in = $signed(csr_wdata[SSIM_W-1:0]);
            CSR_LIGHT_ERR: light_err_in = csr_wdata[LIGHT_W-1:0];
            CSR_LIGHT_HI:  light_hi_in  = csr_wdata[LIGHT_W-1:0];
            CSR_JUMP:      jump_in      = csr_wdata[JUMP_W-1:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_err_ff  <= CONF_ERR_RST;
         conf_warn_ff <= CONF_WARN_RST;
         ssim_err_ff  <= SSIM_ERR_RST;
         ssim_warn_ff <= SSIM_WARN_RST;
         light_err_ff <= LIGHT_ERR_RST;
         light_hi_ff  <= LIGHT_HI_RST;
         jump_ff      <= JUMP_RST;
      end else begin
         conf_err_ff  <= conf_err_in;
         conf_warn_ff <= conf_warn_in;
         ssim_err_ff  <= ssim_err_in;
         ssim_warn_ff <= ssim_warn_in;
         light_err_ff <= light_err_in;
         light_hi_ff  <= light_hi_in;
         jump_ff      <= jump_in;
      end
   end

   // Displacement magnitudes, one bit wider to hold the most negative value
   assign mag_x   = req_shift_x[SHIFT_W-1] ?
                    ((SHIFT_W+1)'(0) - {req_shift_x[SHIFT_W-1], req_shift_x}) :
                    {1'b0, req_shift_x};
   assign mag_y   = req_shift_y[SHIFT_W-1] ?
                    ((SHIFT_W+1)'(0) - {req_shift_y[SHIFT_W-1], req_shift_y}) :
                    {1'b0, req_shift_y};
   assign mag_max = (mag_x > mag_y) ? mag_x : mag_y;

   // Classify the frame: errors always override, warnings only while normal
   always_comb begin
      inst   = ST_NORMAL;
      rsn    = RS_OK;
      normal = 1'b1;
      if (req_confidence < conf_err_ff) begin
         inst = ST_ERROR; rsn = RS_CONF_LOW; normal = 1'b0;
      end else if (req_confidence < conf_warn_ff) begin
         inst = ST_WARN; rsn = RS_CONF_WARN; normal = 1'b0;
      end
      if (req_similarity < ssim_err_ff) begin
         inst = ST_ERROR; rsn = RS_SSIM_ERR; normal = 1'b0;
      end else if (req_similarity < ssim_warn_ff && normal) begin
         inst = ST_WARN; rsn = RS_SSIM_WARN; normal = 1'b0;
      end
      if (req_brightness < light_err_ff) begin
         inst = ST_ERROR; rsn = RS_DARK; normal = 1'b0;
      end else if (req_brightness > light_hi_ff && normal) begin
         inst = ST_WARN; rsn = RS_BRIGHT; normal = 1'b0;
      end
      if (req_frames_tracked > JUMP_MIN_FRAMES && normal &&
          mag_max > {2'b00, jump_ff}) begin
         inst = ST_WARN; rsn = RS_JUMP; normal = 1'b0;
      end
   end

   // Drop requests for targets beyond the table
   assign kind     = kind_type'(req_kind);
   assign in_range = (kind == KIND_RESET_ALL) || (32'(req_target) < NUM_TARGETS);

   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full && in_range;

   always_comb begin
      push_op.kind   = kind;
      push_op.target = req_target;
      push_op.inst   = inst;
      push_op.rsn    = rsn;
   end

endmodule

FILE: sv/tsdc_queue.sv
// Short request queue between the classifying front and the update back
`timescale 1ns / 1ps

module tsdc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  tsdc_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output tsdc_pkg::op_type head_op
);
   import tsdc_pkg::*;

   localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   op_type        slot_ff [QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff,  count_in;
   logic          do_push;
   logic          do_pop;

   assign full       = (count_ff == (AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && !full;
   assign do_pop  = pop && head_valid;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

FILE: sv/tsdc_back.sv
// Back part: per-target debounce read-modify-write and the result register
`timescale 1ns / 1ps
`include "target_status_debounce_classifier_core_assert.svh"

module tsdc_back #(
   parameter int unsigned NUM_TARGETS = tsdc_pkg::NUM_TARGETS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  tsdc_pkg::op_type       head_op,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_confirmed_status,
   output logic [3:0]             rsp_reason,
   output logic                   rsp_is_normal,
   output logic [1:0]             rsp_instant_status
);
   import tsdc_pkg::*;

   localparam int unsigned IDX_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
   localparam int unsigned ENT_W = $bits(entry_type);

   // Update stage
   logic             b_valid_ff, b_valid_in;
   op_type           b_op_ff;
   logic             byp_valid_ff, byp_valid_in;
   entry_type        byp_entry_ff, byp_entry_in;
   logic             b_done;
   logic             advance;
   logic [IDX_W-1:0] head_addr;
   logic [IDX_W-1:0] b_addr;

   // Target flags: known target, and reset since last record write
   logic [NUM_TARGETS-1:0] active_ff,  active_in;
   logic [NUM_TARGETS-1:0] pending_ff, pending_in;

   logic [ENT_W-1:0] ram_rdata;
   entry_type        cur;
   entry_type        wr_entry;
   logic             wr_en;
   run_type          run_nx;
   status_type       nxt;
   logic             t3;
   logic             t5;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   reason_type rsp_reason_ff;
   status_type rsp_inst_ff;

   assign head_addr = IDX_W'(head_op.target);
   assign b_addr    = IDX_W'(b_op_ff.target);

   // Complete when the result slot is free or the request gives no result
   assign b_done  = b_valid_ff &&
                    (b_op_ff.kind != KIND_ANALYZE || !rsp_valid_ff || !rsp_stall);
   assign advance = head_valid && (!b_valid_ff || b_done);
   assign pop     = advance;
   assign wr_en   = b_done && (b_op_ff.kind == KIND_ANALYZE);

   assign b_valid_in = advance ? 1'b1 : (b_done ? 1'b0 : b_valid_ff);

   // Forward the record being written to a following request of the same target
   always_comb begin
      byp_valid_in = byp_valid_ff;
      byp_entry_in = byp_entry_ff;
      if (advance) begin
         byp_valid_in = wr_en && (b_addr == head_addr);
         byp_entry_in = wr_entry;
      end
   end

   tsdc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_TARGETS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (b_addr),
      .wr_data (wr_entry),
      .rd_en   (advance),
      .rd_addr (head_addr),
      .rd_data (ram_rdata)
   );

   // Pick the current record: unknown, reset, forwarded or stored
   always_comb begin
      if (!active_ff[b_addr]) begin
         cur = ENTRY_INIT;
      end else if (pending_ff[b_addr]) begin
         cur = ENTRY_RESET;
      end else if (byp_valid_ff) begin
         cur = byp_entry_ff;
      end else begin
         cur = entry_type'(ram_rdata);
      end
   end

   // Count runs of equal instants, saturating
   always_comb begin
      if (cur.last == b_op_ff.inst) begin
         run_nx = (cur.run < RUN_MAX) ? cur.run + 3'd1 : cur.run;
      end else begin
         run_nx = 3'd1;
      end
   end

   assign t3 = (run_nx >= RUN_SHORT);
   assign t5 = (run_nx >= RUN_MAX);

   // Debounced confirmed state
   always_comb begin
      nxt = cur.state;
      case (cur.state)
         ST_INIT: begin
            if (t3) begin
               nxt = b_op_ff.inst;
            end
         end
         ST_NORMAL: begin
            if (t5 && b_op_ff.inst == ST_ERROR) begin
               nxt = ST_ERROR;
            end else if (t3 && b_op_ff.inst == ST_WARN) begin
               nxt = ST_WARN;
            end
         end
         ST_WARN: begin
            if (t3 && b_op_ff.inst == ST_ERROR) begin
               nxt = ST_ERROR;
            end else if (t3 && b_op_ff.inst == ST_NORMAL) begin
               nxt = ST_NORMAL;
            end
         end
         default: begin
            if (t5 && b_op_ff.inst == ST_NORMAL) begin
               nxt = ST_NORMAL;
            end else if (t3 && b_op_ff.inst == ST_WARN) begin
               nxt = ST_WARN;
            end
         end
      endcase
   end

   always_comb begin
      wr_entry.state  = nxt;
      wr_entry.last   = b_op_ff.inst;
      wr_entry.run    = run_nx;
      if (nxt != cur.state) begin
         wr_entry.reason = (nxt == ST_NORMAL) ? RS_OK : b_op_ff.rsn;
      end else begin
         wr_entry.reason = cur.reason;
      end
   end

   // Update target flags as each request completes
   always_comb begin
      active_in  = active_ff;
      pending_in = pending_ff;
      if (b_done) begin
         case (b_op_ff.kind)
            KIND_ANALYZE: begin
               active_in[b_addr]  = 1'b1;
               pending_in[b_addr] = 1'b0;
            end
            KIND_RESET: begin
               pending_in[b_addr] = pending_ff[b_addr] | active_ff[b_addr];
            end
            KIND_RESET_ALL: begin
               pending_in = pending_ff | active_ff;
            end
            KIND_REMOVE: begin
               active_in[b_addr] = 1'b0;
            end
            default: ;
         endcase
      end
   end

   // Load the result register, drop it once taken
   always_comb begin
      if (wr_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
         pending_ff   <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         byp_valid_ff <= byp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_op_ff <= head_op;
      end
      byp_entry_ff <= byp_entry_in;
      if (wr_en) begin
         rsp_status_ff <= wr_entry.state;
         rsp_reason_ff <= wr_entry.reason;
         rsp_inst_ff   <= b_op_ff.inst;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_confirmed_status = rsp_status_ff;
   assign rsp_reason           = rsp_reason_ff;
   assign rsp_is_normal        = (rsp_status_ff == ST_NORMAL);
   assign rsp_instant_status   = rsp_inst_ff;

   // A written record always carries a run of one to five
   `TSDC_ASSERT_IMP(a_run_range, wr_en, (wr_entry.run != 3'd0 && wr_entry.run <= RUN_MAX), "run count out of range")
   // Leaving the initial state takes at least three equal frames
   `TSDC_ASSERT_IMP(a_init_exit, (wr_en && cur.state == ST_INIT && nxt != ST_INIT), (run_nx >= RUN_SHORT), "early exit from init")
   // A move to normal clears the reason
   `TSDC_ASSERT_IMP(a_normal_ok, (wr_en && nxt == ST_NORMAL && cur.state != ST_NORMAL), (wr_entry.reason == RS_OK), "normal without ok reason")
   // A loaded result is never overwritten while stalled
   `TSDC_ASSERT_NEXT(a_rsp_hold, (rsp_valid_ff && rsp_stall), (rsp_valid_ff && !$past(wr_en)), "result overwritten")

endmodule

FILE: test/tb_target_status_debounce_classifier_core.sv
// Self-checking testbench for the target status debounce classifier core
`timescale 1ns / 1ps

module tb_target_status_debounce_classifier_core;
   import tsdc_pkg::*;

   localparam int NUM_TGT      = 16;
   localparam int SETTLE_CYC   = 8;
   localparam int LIMIT_CYC    = 200000;
   localparam int MAX_REPORTS  = 10;
   localparam int GOOD_CONF    = 900;
   localparam int GOOD_LIGHT   = 2048;
   localparam int GOOD_SIM     = 16000;

   // One request as seen on the req_ channel
   typedef struct {
      kind_type              kind;
      logic [TARGET_W-1:0]   target;
      logic [CONF_W-1:0]     conf;
      logic [LIGHT_W-1:0]    light;
      logic signed [SSIM_W-1:0]  sim;
      logic signed [SHIFT_W-1:0] sx;
      logic signed [SHIFT_W-1:0] sy;
      logic [FRAMES_W-1:0]   frames;
   } meas_type;

   // One result as seen on the rsp_ channel
   typedef struct packed {
      status_type confirmed;
      reason_type reason;
      logic       normal;
      status_type instant;
   } status_rsp_type;

   typedef struct {
      meas_type       m;
      bit             typed;
      status_rsp_type e;
   } row_type;

   typedef enum {AIM_NORMAL, AIM_WARN, AIM_ERROR} aim_type;
   typedef enum {SET_DEFAULTS, SET_SPREAD, SET_FLOOR, SET_CEILING, SET_RAW} setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0]            req_kind = '0;
   logic [TARGET_W-1:0]   req_target = '0;
   logic [CONF_W-1:0]     req_confidence = '0;
   logic [LIGHT_W-1:0]    req_brightness = '0;
   logic signed [SSIM_W-1:0]  req_similarity = '0;
   logic signed [SHIFT_W-1:0] req_shift_x = '0;
   logic signed [SHIFT_W-1:0] req_shift_y = '0;
   logic [FRAMES_W-1:0]   req_frames_tracked = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_confirmed_status;
   logic [3:0] rsp_reason;
   logic       rsp_is_normal;
   logic [1:0] rsp_instant_status;

   // Threshold mirror
   int conf_err, conf_warn, ssim_err, ssim_warn, light_err, light_hi, jump_lim;

   // Per-target debounce mirror
   bit         tgt_active [NUM_TGT];
   status_type tgt_state  [NUM_TGT];
   reason_type tgt_reason [NUM_TGT];
   status_type tgt_last   [NUM_TGT];
   run_type    tgt_run    [NUM_TGT];

   status_rsp_type status_due[$];
   row_type        plan[$];
   aim_type        mood [NUM_TGT];
   reason_type  warn_srcs [4] = '{RS_CONF_WARN, RS_SSIM_WARN, RS_BRIGHT, RS_JUMP};
   reason_type  err_srcs  [3] = '{RS_CONF_LOW, RS_SSIM_ERR, RS_DARK};
   setting_type sched [6] = '{SET_DEFAULTS, SET_SPREAD, SET_FLOOR, SET_CEILING,
                              SET_RAW, SET_SPREAD};
   int          sched_len [6] = '{200, 200, 100, 100, 200, 150};

   bit          calm = 1'b0;
   int          mismatches = 0;
   int          stall_left = 0;
   int unsigned cycles = 0;

   target_status_debounce_classifier_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_target          (req_target),
      .req_confidence      (req_confidence),
      .req_brightness      (req_brightness),
      .req_similarity      (req_similarity),
      .req_shift_x         (req_shift_x),
      .req_shift_y         (req_shift_y),
      .req_frames_tracked  (req_frames_tracked),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_confirmed_status(rsp_confirmed_status),
      .rsp_reason          (rsp_reason),
      .rsp_is_normal       (rsp_is_normal),
      .rsp_instant_status  (rsp_instant_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Uniform draw in [lo, hi]; collapse to lo when the range is empty
   function automatic int pick(input int lo, input int hi);
      if (hi < lo) return lo;
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   function automatic void wipe_target(input int t, input reason_type why);
      tgt_state[t]  = ST_INIT;
      tgt_reason[t] = why;
      tgt_last[t]   = ST_INIT;
      tgt_run[t]    = '0;
   endfunction

   // Classify one frame, advance the debounce record and return its status; other kinds only update the mirror
   function automatic bit next_target_status(input meas_type m, output status_rsp_type r);
      int t, ax, ay;
      status_type inst, cur, nxt;
      reason_type rsn;
      bit clean, t3, t5;
      r = '0;
      t = int'(m.target);
      if (m.kind == KIND_RESET_ALL) begin
         for (int i = 0; i < NUM_TGT; i++)
            if (tgt_active[i]) wipe_target(i, RS_RESET);
         return 1'b0;
      end
      if (t >= NUM_TGT) return 1'b0;
      if (m.kind == KIND_RESET) begin
         if (tgt_active[t]) wipe_target(t, RS_RESET);
         return 1'b0;
      end
      if (m.kind == KIND_REMOVE) begin
         tgt_active[t] = 1'b0;
         return 1'b0;
      end

      // errors always override, warnings only while the frame is still clean
      inst = ST_NORMAL;
      rsn = RS_OK;
      clean = 1'b1;
      if (int'(m.conf) < conf_err) begin
         inst = ST_ERROR; rsn = RS_CONF_LOW; clean = 1'b0;
      end else if (int'(m.conf) < conf_warn) begin
         inst = ST_WARN; rsn = RS_CONF_WARN; clean = 1'b0;
      end
      if (int'(m.sim) < ssim_err) begin
         inst = ST_ERROR; rsn = RS_SSIM_ERR; clean = 1'b0;
      end else if (int'(m.sim) < ssim_warn && clean) begin
         inst = ST_WARN; rsn = RS_SSIM_WARN; clean = 1'b0;
      end
      if (int'(m.light) < light_err) begin
         inst = ST_ERROR; rsn = RS_DARK; clean = 1'b0;
      end else if (int'(m.light) > light_hi && clean) begin
         inst = ST_WARN; rsn = RS_BRIGHT; clean = 1'b0;
      end
      if (m.frames > JUMP_MIN_FRAMES && clean) begin
         ax = int'(m.sx);
         ay = int'(m.sy);
         if (ax < 0) ax = -ax;
         if (ay < 0) ay = -ay;
         if ((ax > ay ? ax : ay) > jump_lim) begin
            inst = ST_WARN; rsn = RS_JUMP; clean = 1'b0;
         end
      end

      if (!tgt_active[t]) begin
         tgt_active[t] = 1'b1;
         wipe_target(t, RS_INIT);
      end

      // count the run of equal instants, saturating
      if (tgt_last[t] == inst) begin
         if (tgt_run[t] < RUN_MAX) tgt_run[t] = tgt_run[t] + 3'd1;
      end else begin
         tgt_last[t] = inst;
         tgt_run[t]  = 3'd1;
      end
      t3 = tgt_run[t] >= RUN_SHORT;
      t5 = tgt_run[t] >= RUN_MAX;

      cur = tgt_state[t];
      nxt = cur;
      case (cur)
         ST_INIT: begin
            if (t3) nxt = inst;
         end
         ST_NORMAL: begin
            if (inst == ST_ERROR && t5) nxt = ST_ERROR;
            else if (inst == ST_WARN && t3) nxt = ST_WARN;
         end
         ST_WARN: begin
            if (inst == ST_ERROR && t3) nxt = ST_ERROR;
            else if (inst == ST_NORMAL && t3) nxt = ST_NORMAL;
         end
         default: begin
            if (inst == ST_NORMAL && t5) nxt = ST_NORMAL;
            else if (inst == ST_WARN && t3) nxt = ST_WARN;
         end
      endcase
      if (nxt != cur) begin
         tgt_state[t]  = nxt;
         tgt_reason[t] = (nxt == ST_NORMAL) ? RS_OK : rsn;
      end

      r.confirmed = tgt_state[t];
      r.reason    = tgt_reason[t];
      r.normal    = (tgt_state[t] == ST_NORMAL);
      r.instant   = inst;
      return 1'b1;
   endfunction

   function automatic void add_row(input kind_type k, input int tgt, conf, light, sim,
                                   sx, sy, frames, input bit typed, input status_type cs,
                                   input reason_type rs, input status_type ins);
      row_type r;
      r.m.kind   = k;
      r.m.target = TARGET_W'(tgt);
      r.m.conf   = CONF_W'(conf);
      r.m.light  = LIGHT_W'(light);
      r.m.sim    = SSIM_W'(sim);
      r.m.sx     = SHIFT_W'(sx);
      r.m.sy     = SHIFT_W'(sy);
      r.m.frames = FRAMES_W'(frames);
      r.typed    = typed;
      r.e.confirmed = cs;
      r.e.reason    = rs;
      r.e.normal    = (cs == ST_NORMAL);
      r.e.instant   = ins;
      plan.push_back(r);
   endfunction

   // Build a random request: mostly runs of one class per target, some noise
   function automatic meas_type roll_request();
      meas_type m;
      int roll, t, hot, mag;
      reason_type src;
      roll = $urandom_range(99, 0);
      hot  = $urandom_range(99, 0);
      t = (hot < 60) ? $urandom_range(1, 0) : (hot < 85) ? $urandom_range(3, 0)
                     : $urandom_range(NUM_TGT - 1, 0);
      if ($urandom_range(5, 0) == 0) mood[t] = aim_type'($urandom_range(2, 0));

      if (roll < 12) begin
         m.kind   = ($urandom_range(3, 0) == 0) ? kind_type'($urandom_range(3, 0))
                                                : KIND_ANALYZE;
         m.target = TARGET_W'($urandom);
         m.conf   = CONF_W'($urandom);
         m.light  = LIGHT_W'($urandom);
         m.sim    = SSIM_W'($urandom);
         m.sx     = SHIFT_W'($urandom);
         m.sy     = SHIFT_W'($urandom);
         m.frames = FRAMES_W'($urandom);
         return m;
      end

      m.kind = (roll < 15) ? KIND_RESET : (roll < 18) ? KIND_REMOVE : KIND_ANALYZE;
      m.target = TARGET_W'(t);
      // start from a clean frame under the current thresholds
      m.conf   = CONF_W'(pick(conf_warn > conf_err ? conf_warn : conf_err, 1023));
      m.sim    = SSIM_W'(pick(ssim_warn > ssim_err ? ssim_warn : ssim_err, 32767));
      m.light  = LIGHT_W'(pick(light_err, light_hi));
      m.sx     = SHIFT_W'(pick(-jump_lim, jump_lim));
      m.sy     = SHIFT_W'(pick(-jump_lim, jump_lim));
      m.frames = FRAMES_W'(pick(0, 65535));

      // spoil one measurement to match the target's current class
      if (mood[t] == AIM_WARN) begin
         src = warn_srcs[$urandom_range(3, 0)];
         case (src)
            RS_CONF_WARN: m.conf  = CONF_W'(pick(conf_err, conf_warn - 1));
            RS_SSIM_WARN: m.sim   = SSIM_W'(pick(ssim_err, ssim_warn - 1));
            RS_BRIGHT:    m.light = LIGHT_W'(pick(light_hi + 1, 8191));
            default: begin
               m.frames = FRAMES_W'(pick(6, 65535));
               mag = pick(jump_lim + 1, 32768);
               mag = (mag == 32768 || $urandom_range(1, 0)) ? -mag : mag;
               if ($urandom_range(1, 0)) m.sx = SHIFT_W'(mag);
               else m.sy = SHIFT_W'(mag);
            end
         endcase
      end else if (mood[t] == AIM_ERROR) begin
         src = err_srcs[$urandom_range(2, 0)];
         case (src)
            RS_CONF_LOW: m.conf = CONF_W'(pick(0, conf_err - 1));
            RS_SSIM_ERR: m.sim  = SSIM_W'(pick(-32768, ssim_err - 1));
            default:     m.light = LIGHT_W'(pick(0, light_err - 1));
         endcase
      end
      return m;
   endfunction

   // Present one request, hold it until taken, then record its expected status
   task automatic issue(input meas_type m, input bit typed,
                        input status_rsp_type typed_exp);
      int gap;
      status_rsp_type got;
      gap = calm ? 0 : $urandom_range(9, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= m.kind;
      req_target         <= m.target;
      req_confidence     <= m.conf;
      req_brightness     <= m.light;
      req_similarity     <= m.sim;
      req_shift_x        <= m.sx;
      req_shift_y        <= m.sy;
      req_frames_tracked <= m.frames;
      do @(posedge clock); while (req_stall);
      if (next_target_status(m, got)) status_due.push_back(typed ? typed_exp : got);
   endtask

   // Drain the block, then write all seven thresholds for the next setting
   task automatic load_thresholds(input setting_type s);
      logic [CSR_DATA_W-1:0] v [8];
      int lo;
      case (s)
         SET_DEFAULTS: begin
            v[CSR_CONF_ERR]  = 16'(CONF_ERR_RST);
            v[CSR_CONF_WARN] = 16'(CONF_WARN_RST);
            v[CSR_SSIM_ERR]  = 16'(SSIM_ERR_RST);
            v[CSR_SSIM_WARN] = 16'(SSIM_WARN_RST);
            v[CSR_LIGHT_ERR] = 16'(LIGHT_ERR_RST);
            v[CSR_LIGHT_HI]  = 16'(LIGHT_HI_RST);
            v[CSR_JUMP]      = 16'(JUMP_RST);
         end
         SET_SPREAD: begin
            lo = pick(200, 800);
            v[CSR_CONF_ERR]  = 16'(lo);
            v[CSR_CONF_WARN] = 16'(pick(lo, 1000));
            lo = pick(-16384, 16000);
            v[CSR_SSIM_ERR]  = 16'(lo);
            v[CSR_SSIM_WARN] = 16'(pick(lo, 16384));
            lo = pick(0, 2048);
            v[CSR_LIGHT_ERR] = 16'(lo);
            v[CSR_LIGHT_HI]  = 16'(pick(lo, 4096));
            v[CSR_JUMP]      = 16'(pick(0, 6000));
         end
         SET_FLOOR: begin
            v[CSR_CONF_ERR]  = '0;
            v[CSR_CONF_WARN] = '0;
            v[CSR_SSIM_ERR]  = 16'h8000;
            v[CSR_SSIM_WARN] = 16'h8000;
            v[CSR_LIGHT_ERR] = '0;
            v[CSR_LIGHT_HI]  = '0;
            v[CSR_JUMP]      = '0;
         end
         SET_CEILING: begin
            v[CSR_CONF_ERR]  = 16'd1023;
            v[CSR_CONF_WARN] = 16'd1023;
            v[CSR_SSIM_ERR]  = 16'h7FFF;
            v[CSR_SSIM_WARN] = 16'h7FFF;
            v[CSR_LIGHT_ERR] = 16'd8191;
            v[CSR_LIGHT_HI]  = 16'd8191;
            v[CSR_JUMP]      = 16'd32767;
         end
         default: begin
            v[CSR_CONF_ERR]  = 16'($urandom_range(1023, 0));
            v[CSR_CONF_WARN] = 16'($urandom_range(1023, 0));
            v[CSR_SSIM_ERR]  = 16'($urandom);
            v[CSR_SSIM_WARN] = 16'($urandom);
            v[CSR_LIGHT_ERR] = 16'($urandom_range(8191, 0));
            v[CSR_LIGHT_HI]  = 16'($urandom_range(8191, 0));
            v[CSR_JUMP]      = 16'($urandom_range(32767, 0));
         end
      endcase

      // hold off until every result is back and the pipeline has emptied
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);

      for (int i = 0; i <= int'(CSR_JUMP); i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= v[i];
         do @(posedge clock); while (!csr_ready);
         case (CSR_IDX_W'(i))
            CSR_CONF_ERR:  conf_err  = int'(v[i][CONF_W-1:0]);
            CSR_CONF_WARN: conf_warn = int'(v[i][CONF_W-1:0]);
            CSR_SSIM_ERR:  ssim_err  = int'($signed(v[i]));
            CSR_SSIM_WARN: ssim_warn = int'($signed(v[i]));
            CSR_LIGHT_ERR: light_err = int'(v[i][LIGHT_W-1:0]);
            CSR_LIGHT_HI:  light_hi  = int'(v[i][LIGHT_W-1:0]);
            default:       jump_lim  = int'(v[i][JUMP_W-1:0]);
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Stimulus
   initial begin
      conf_err  = int'(CONF_ERR_RST);
      conf_warn = int'(CONF_WARN_RST);
      ssim_err  = int'(SSIM_ERR_RST);
      ssim_warn = int'(SSIM_WARN_RST);
      light_err = int'(LIGHT_ERR_RST);
      light_hi  = int'(LIGHT_HI_RST);
      jump_lim  = int'(JUMP_RST);
      for (int i = 0; i < NUM_TGT; i++) begin
         tgt_active[i] = 1'b0;
         wipe_target(i, RS_INIT);
         mood[i] = AIM_NORMAL;
      end

      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed walk under the reset thresholds
      add_row(KIND_ANALYZE, 0, GOOD_CONF, GOOD_LIGHT, GOOD_SIM, 0, 0, 0,
              1, ST_INIT, RS_INIT, ST_NORMAL);
      add_row(KIND_ANALYZE, 0, GOOD_CONF, GOOD_LIGHT, GOOD_SIM, 0, 0, 0,
              1, ST_INIT, RS_INIT, ST_NORMAL);
      add_row(KIND_ANALYZE, 0, GOOD_CONF, GOOD_LIGHT, GOOD_SIM, 0, 0, 0,
              1, ST_NORMAL, RS_OK, ST_NORMAL);
      add_row(KIND_ANALYZE, 1, 0, GOOD_LIGHT, GOOD_SIM, 0, 0, 0,
              1, ST_INIT, RS_INIT, ST_ERROR);
      add_row(KIND_ANALYZE, 1, 1023, 0, GOOD_SIM, 0, 0, 0,
              1, ST_INIT, RS_INIT, ST_ERROR);
      add_row(KIND_ANALYZE, 1, GOOD_CONF, GOOD_LIGHT, -32768, 0, 0, 0,
              1, ST_ERROR, RS_SSIM_ERR, ST_ERROR);
      add_row(KIND_ANALYZE, 2, 600, GOOD_LIGHT, GOOD_SIM, 0, 0, 0,
              1, ST_INIT, RS_INIT, ST_WARN);
      add_row(KIND_ANALYZE, 2, GOOD_CONF, GOOD_LIGHT, 11000, 0, 0, 0,
              0, ST_INIT, RS_OK, ST_INIT);
      add_row(KIND_ANALYZE, 2, GOOD_CONF, 8191, GOOD_SIM, 0, 0, 0,
              1, ST_WARN, RS_BRIGHT, ST_WARN);
      add_row(KIND_ANALYZE, 3, GOOD_CONF, GOOD_LIGHT, GOOD_SIM, -32768, 32767, 65535,
              1, ST_INIT, RS_INIT, ST_WARN);
      add_row(KIND_ANALYZE, 3, GOOD_CONF, GOOD_LIGHT, GOOD_SIM, 32767, 0, 5,
              1, ST_INIT, RS_INIT, ST_NORMAL);
      add_row(KIND_ANALYZE, 3, GOOD_CONF, GOOD_LIGHT, GOOD_SIM, 1281, 0, 6,
              1, ST_INIT, RS_INIT, ST_WARN);
      add_row(KIND_ANALYZE, 3, GOOD_CONF, GOOD_LIGHT, GOOD_SIM, 1280, -1280, 6,
              0, ST_INIT, RS_OK, ST_INIT);
      add_row(KIND_ANALYZE, 2, 0, GOOD_LIGHT, GOOD_SIM, 0, 0, 0,
              1, ST_WARN, RS_BRIGHT, ST_ERROR);
      add_row(KIND_RESET, 2, 0, 0, 0, 0, 0, 0, 0, ST_INIT, RS_OK, ST_INIT);
      add_row(KIND_ANALYZE, 2, GOOD_CONF, GOOD_LIGHT, GOOD_SIM, 0, 0, 0,
              1, ST_INIT, RS_RESET, ST_NORMAL);
      add_row(KIND_REMOVE, 3, 0, 0, 0, 0, 0, 0, 0, ST_INIT, RS_OK, ST_INIT);
      add_row(KIND_ANALYZE, 3, 600, GOOD_LIGHT, GOOD_SIM, 0, 0, 0,
              1, ST_INIT, RS_INIT, ST_WARN);
      add_row(KIND_RESET_ALL, 9, 0, 0, 0, 0, 0, 0, 0, ST_INIT, RS_OK, ST_INIT);
      add_row(KIND_ANALYZE, 0, GOOD_CONF, GOOD_LIGHT, GOOD_SIM, 0, 0, 0,
              1, ST_INIT, RS_RESET, ST_NORMAL);
      add_row(KIND_RESET, 5, 0, 0, 0, 0, 0, 0, 0, ST_INIT, RS_OK, ST_INIT);
      add_row(KIND_ANALYZE, 5, GOOD_CONF, GOOD_LIGHT, GOOD_SIM, 0, 0, 0,
              1, ST_INIT, RS_INIT, ST_NORMAL);
      add_row(KIND_ANALYZE, 6, 0, 4000, 11000, 0, 0, 0,
              1, ST_INIT, RS_INIT, ST_ERROR);
      add_row(KIND_ANALYZE, 6, 600, GOOD_LIGHT, 0, 0, 0, 0,
              0, ST_INIT, RS_OK, ST_INIT);
      add_row(KIND_ANALYZE, 6, GOOD_CONF, 0, GOOD_SIM, 0, 0, 0,
              1, ST_ERROR, RS_DARK, ST_ERROR);
      add_row(KIND_ANALYZE, 15, 1023, 4096, 16384, 0, 0, 0,
              1, ST_INIT, RS_INIT, ST_WARN);
      foreach (plan[i]) issue(plan[i].m, plan[i].typed, plan[i].e);

      // random phases, one threshold setting each
      foreach (sched[p]) begin
         load_thresholds(sched[p]);
         for (int n = 0; n < sched_len[p]; n++) begin
            calm = ((n / 40) % 4 == 3);
            issue(roll_request(), 1'b0, '0);
         end
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatches == 0 && status_due.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Stall the result channel for a random count after each taken result
   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else if (rsp_valid && !rsp_stall) begin
         draw = calm ? 0 : $urandom_range(9, 0);
         stall_left <= draw;
         rsp_stall  <= (draw != 0);
      end
   end

   // Compare each taken result with the oldest expected status
   always @(posedge clock) begin
      status_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (status_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: state %0d reason %0d normal %0b instant %0d",
                        rsp_confirmed_status, rsp_reason, rsp_is_normal,
                        rsp_instant_status);
         end else begin
            want = status_due.pop_front();
            if (want.confirmed !== rsp_confirmed_status || want.reason !== rsp_reason ||
                want.normal !== rsp_is_normal || want.instant !== rsp_instant_status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("status mismatch: expected %0d/%0d/%0b/%0d got %0d/%0d/%0b/%0d",
                           want.confirmed, want.reason, want.normal, want.instant,
                           rsp_confirmed_status, rsp_reason, rsp_is_normal,
                           rsp_instant_status);
            end
         end
      end
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYC) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
